### rtl/exlex_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// exlex_pkg
// types, token codes and result builders shared by the expression lexer
// ----------------------------------------------------------------------------
package exlex_pkg;

	// byte index width, wraps at this many bits
	localparam int IDX_W   = 16;
	// most results one input byte can cause
	localparam int RES_MAX = 6;
	localparam int CNT_W   = $clog2(RES_MAX + 1);
	localparam int RD_W    = $clog2(RES_MAX);

	// token type codes
	localparam logic [5:0] K_LPAREN = 6'd0;
	localparam logic [5:0] K_RPAREN = 6'd1;
	localparam logic [5:0] K_LBRACK = 6'd2;
	localparam logic [5:0] K_RBRACK = 6'd3;
	localparam logic [5:0] K_LBRACE = 6'd4;
	localparam logic [5:0] K_RBRACE = 6'd5;
	localparam logic [5:0] K_DOTDOT = 6'd6;
	localparam logic [5:0] K_COMMA  = 6'd7;
	localparam logic [5:0] K_EQ     = 6'd8;
	localparam logic [5:0] K_NE     = 6'd9;
	localparam logic [5:0] K_LT     = 6'd10;
	localparam logic [5:0] K_LE     = 6'd11;
	localparam logic [5:0] K_GT     = 6'd12;
	localparam logic [5:0] K_GE     = 6'd13;
	localparam logic [5:0] K_ADD    = 6'd14;
	localparam logic [5:0] K_SUB    = 6'd15;
	localparam logic [5:0] K_MUL    = 6'd16;
	localparam logic [5:0] K_DIV    = 6'd17;
	localparam logic [5:0] K_MOD    = 6'd18;
	localparam logic [5:0] K_LAND   = 6'd19;
	localparam logic [5:0] K_LOR    = 6'd20;
	localparam logic [5:0] K_LNOT   = 6'd21;
	localparam logic [5:0] K_BAND   = 6'd22;
	localparam logic [5:0] K_BOR    = 6'd23;
	localparam logic [5:0] K_BNOT   = 6'd24;
	localparam logic [5:0] K_IDENT  = 6'd25;
	localparam logic [5:0] K_FLOAT  = 6'd26;
	localparam logic [5:0] K_INT    = 6'd27;
	localparam logic [5:0] K_STRING = 6'd28;
	localparam logic [5:0] K_QUEST  = 6'd29;
	localparam logic [5:0] K_COLON  = 6'd30;
	localparam logic [5:0] K_ASSIGN = 6'd31;
	localparam logic [5:0] K_ASADD  = 6'd32;
	localparam logic [5:0] K_ASSUB  = 6'd33;
	localparam logic [5:0] K_ASMUL  = 6'd34;
	localparam logic [5:0] K_ASDIV  = 6'd35;
	localparam logic [5:0] K_ASMOD  = 6'd36;
	localparam logic [5:0] K_SHL    = 6'd37;
	localparam logic [5:0] K_SHR    = 6'd38;
	localparam logic [5:0] K_XOR    = 6'd39;
	// internal open-token and classifier codes
	localparam logic [5:0] K_NONE   = 6'd40;
	localparam logic [5:0] K_SPACE  = 6'd41;
	localparam logic [5:0] K_BAD    = 6'd42;
	localparam logic [5:0] K_SAME   = 6'd43;

	// error kinds
	localparam logic ERR_SYNTAX   = 1'b0;
	localparam logic ERR_UNTERM   = 1'b1;

	typedef struct packed {
		logic [7:0] char_in;
		logic       expr_end;
	} in_t;

	typedef struct packed {
		logic [5:0]  kind_code;
		logic [7:0]  text_byte;
		logic        is_text;
		logic        token_done;
		logic        is_error;
		logic        error_kind;
		logic [15:0] error_pos;
		logic        expr_done;
		logic        run_last;
	} out_t;

	typedef struct packed {
		logic [7:0] prior_byte;
		logic [5:0] open_kind;
		logic       seen_dot;
		logic       skip_pending;
		logic       error_latched;
	} lex_state_t;

	localparam lex_state_t LEX_IDLE = '{
		prior_byte:    8'h20,
		open_kind:     K_NONE,
		seen_dot:      1'b0,
		skip_pending:  1'b0,
		error_latched: 1'b0
	};

	function automatic out_t mk_text(input logic [7:0] c);
		out_t r;
		r = '0;
		r.text_byte = c;
		r.is_text   = 1'b1;
		return r;
	endfunction

	function automatic out_t mk_done(input logic [5:0] k);
		out_t r;
		r = '0;
		r.kind_code  = k;
		r.token_done = 1'b1;
		return r;
	endfunction

	function automatic out_t mk_err(input logic ek, input logic [15:0] p);
		out_t r;
		r = '0;
		r.is_error   = 1'b1;
		r.error_kind = ek;
		r.error_pos  = p;
		return r;
	endfunction

	function automatic out_t mk_xdone();
		out_t r;
		r = '0;
		r.expr_done = 1'b1;
		return r;
	endfunction

	// an open token that a flush closes
	function automatic logic flush_valid(input lex_state_t s);
		return (s.open_kind != K_NONE) && (s.open_kind != K_SPACE);
	endfunction

	// number tokens close as floating or integer
	function automatic logic [5:0] flush_code(input lex_state_t s);
		if (s.open_kind == K_FLOAT) begin
			return s.seen_dot ? K_FLOAT : K_INT;
		end
		return s.open_kind;
	endfunction

endpackage
`default_nettype wire

### rtl/expression_lexer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// expression_lexer
// byte-serial expression lexer with one byte of lookahead
// ----------------------------------------------------------------------------
// channel   role     payload                 transfer when
// char      sink     exlex_pkg::in_t         char_valid && !char_stall
// lex       source   exlex_pkg::out_t        lex_valid && !lex_stall
//
// a byte goes into the input register, then both lexer passes (held byte
// against the new byte, and on expression end the new byte against a space)
// settle combinationally and load the result bank. the bank drains one
// result per lex transfer and takes the next byte's results as its last
// one goes out, so a lex stall holds the input; up to 6 results per byte.
// reset clears lexer state, the input register's valid flag and the bank's count; no sweep.
// a stalled lex channel holds its result and stalls char once the byte in
// the input register has nowhere to go.
// ----------------------------------------------------------------------------
module expression_lexer (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            char_valid,
	output logic                 char_stall,
	input  wire exlex_pkg::in_t  char_data,
	output logic                 lex_valid,
	input  wire logic            lex_stall,
	output exlex_pkg::out_t      lex_data
);
	import exlex_pkg::*;

	// input register
	logic       valid_s1;
	in_t        data_s1;

	// lexer state
	logic [7:0]       held_q;
	logic             held_vld_q;
	logic [IDX_W-1:0] idx_q;
	lex_state_t       lex_q;

	// pass results
	lex_state_t       st1, st2;
	out_t [1:0]       r1, r2;
	logic [1:0]       c1, c2;
	logic [IDX_W-1:0] pos_m1, pos_p1;

	// end-of-expression tail
	logic             tail_v;
	out_t             tail_r;

	// packed results for the bank
	out_t [RES_MAX-1:0] cand;
	logic [RES_MAX-1:0] cand_v;
	out_t [RES_MAX-1:0] nb;
	logic [CNT_W-1:0]   ncnt;

	logic free;
	logic adv;

	assign pos_m1 = idx_q - IDX_W'(1);
	assign pos_p1 = idx_q + IDX_W'(1);

	// the byte in the input register moves on once the bank can take its results
	assign adv        = valid_s1 && free;
	assign char_stall = valid_s1 && !free;

	// held byte, looking ahead at the new byte
	exlex_step u_pass_held (
		.en      (held_vld_q),
		.st_in   (lex_q),
		.b       (held_q),
		.n       (data_s1.char_in),
		.pos     (pos_m1),
		.st_out  (st1),
		.res     (r1),
		.res_cnt (c1)
	);

	// final byte, looking ahead at a space
	exlex_step u_pass_last (
		.en      (data_s1.expr_end),
		.st_in   (st1),
		.b       (data_s1.char_in),
		.n       (8'h20),
		.pos     (idx_q),
		.st_out  (st2),
		.res     (r2),
		.res_cnt (c2)
	);

	// close whatever is still open at the expression end; an open string is an unterminated error
	always_comb begin
		tail_v = 1'b0;
		tail_r = '0;
		if (!st2.error_latched) begin
			if (st2.open_kind == K_STRING) begin
				tail_v = 1'b1;
				tail_r = mk_err(ERR_UNTERM, 16'(pos_p1));
			end else if (flush_valid(st2)) begin
				tail_v = 1'b1;
				tail_r = mk_done(flush_code(st2));
			end
		end
	end

	// gather results in order, packed to the front
	always_comb begin
		cand[0]   = r1[0];
		cand[1]   = r1[1];
		cand[2]   = r2[0];
		cand[3]   = r2[1];
		cand[4]   = tail_r;
		cand[5]   = mk_xdone();
		cand_v[0] = (c1 != 2'd0);
		cand_v[1] = (c1 == 2'd2);
		cand_v[2] = data_s1.expr_end && (c2 != 2'd0);
		cand_v[3] = data_s1.expr_end && (c2 == 2'd2);
		cand_v[4] = data_s1.expr_end && tail_v;
		cand_v[5] = data_s1.expr_end;
		nb   = '0;
		ncnt = '0;
		for (int k = 0; k < RES_MAX; k++) begin
			if (cand_v[k]) begin
				nb[ncnt[RD_W-1:0]] = cand[k];
				ncnt               = ncnt + CNT_W'(1);
			end
		end
	end

	exlex_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (adv),
		.load_res  (nb),
		.load_cnt  (ncnt),
		.free      (free),
		.lex_valid (lex_valid),
		.lex_stall (lex_stall),
		.lex_data  (lex_data)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!char_stall) begin
			valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_valid && !char_stall) begin
			data_s1 <= char_data;
		end
	end

	// lexer state, cleared again after every expression end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q     <= '0;
			held_vld_q <= 1'b0;
			idx_q      <= '0;
			lex_q      <= LEX_IDLE;
		end else if (adv) begin
			if (data_s1.expr_end) begin
				held_q     <= '0;
				held_vld_q <= 1'b0;
				idx_q      <= '0;
				lex_q      <= LEX_IDLE;
			end else begin
				held_q     <= data_s1.char_in;
				held_vld_q <= 1'b1;
				idx_q      <= pos_p1;
				lex_q      <= st1;
			end
		end
	end

endmodule
`default_nettype wire

### rtl/exlex_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// exlex_step
// classifies one byte against its lookahead and the open token
// ----------------------------------------------------------------------------
module exlex_step (
	input  wire logic                         en,
	input  wire exlex_pkg::lex_state_t        st_in,
	input  wire logic [7:0]                   b,
	input  wire logic [7:0]                   n,
	input  wire logic [exlex_pkg::IDX_W-1:0]  pos,
	output exlex_pkg::lex_state_t             st_out,
	output exlex_pkg::out_t [1:0]             res,
	output logic [1:0]                        res_cnt
);
	import exlex_pkg::*;

	function automatic logic is_dig(input logic [7:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	function automatic logic is_let(input logic [7:0] c);
		return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
	endfunction

	function automatic logic is_aln(input logic [7:0] c);
		return is_dig(c) || is_let(c);
	endfunction

	function automatic logic is_spc(input logic [7:0] c);
		return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
	endfunction

	// single-byte operator codes; +, -, *, / and % pair with = before this is tried
	function automatic logic [5:0] single_code(input logic [7:0] c);
		logic [5:0] k;
		unique case (c)
			"~":     k = K_BNOT;
			",":     k = K_COMMA;
			"+":     k = K_ADD;
			"-":     k = K_SUB;
			"*":     k = K_MUL;
			"/":     k = K_DIV;
			"%":     k = K_MOD;
			"^":     k = K_XOR;
			"(":     k = K_LPAREN;
			")":     k = K_RPAREN;
			"[":     k = K_LBRACK;
			"]":     k = K_RBRACK;
			"{":     k = K_LBRACE;
			"}":     k = K_RBRACE;
			default: k = K_BAD;
		endcase
		return k;
	endfunction

	logic [5:0] t;
	logic       eat;
	logic       dot_set;
	logic [15:0] epos;

	assign epos = 16'(pos);

	// classifier, order decides
	always_comb begin
		t       = K_BAD;
		eat     = 1'b0;
		dot_set = 1'b0;
		priority if (is_spc(b)) begin
			t = K_SPACE;
		end else if ((b == ".") && (n == ".")) begin
			if (st_in.open_kind != K_DOTDOT) begin
				t   = K_DOTDOT;
				eat = 1'b1;
			end
		end else if (b == "?") begin
			t = K_QUEST;
		end else if (b == ":") begin
			t = K_COLON;
		end else if ((b == "=") && (n != "=")) begin
			t = K_ASSIGN;
		end else if ((n == "=") && ((b == "+") || (b == "-") || (b == "*") ||
				(b == "/") || (b == "%"))) begin
			eat = 1'b1;
			unique case (b)
				"+":     t = K_ASADD;
				"-":     t = K_ASSUB;
				"*":     t = K_ASMUL;
				"/":     t = K_ASDIV;
				default: t = K_ASMOD;
			endcase
		end else if (b == "<") begin
			eat = (n == "<") || (n == "=");
			t   = (n == "<") ? K_SHL : ((n == "=") ? K_LE : K_LT);
		end else if (b == ">") begin
			eat = (n == ">") || (n == "=");
			t   = (n == ">") ? K_SHR : ((n == "=") ? K_GE : K_GT);
		end else if (b == "=") begin
			t   = K_EQ;
			eat = 1'b1;
		end else if (b == "!") begin
			eat = (n == "=");
			t   = eat ? K_NE : K_LNOT;
		end else if (b == "|") begin
			eat = (n == "|");
			t   = eat ? K_LOR : K_BOR;
		end else if (b == "&") begin
			eat = (n == "&");
			t   = eat ? K_LAND : K_BAND;
		end else if (single_code(b) != K_BAD) begin
			t = single_code(b);
		end else if ((st_in.open_kind == K_FLOAT) && is_dig(b)) begin
			t = K_SAME;
		end else if ((st_in.open_kind == K_FLOAT) && (b == ".") && !st_in.seen_dot &&
				is_dig(n)) begin
			t       = K_SAME;
			dot_set = 1'b1;
		end else if ((st_in.open_kind == K_IDENT) && (is_aln(b) || (b == "_"))) begin
			t = K_SAME;
		end else if (is_dig(b)) begin
			t = K_FLOAT;
		end else if ((st_in.open_kind == K_FLOAT) && is_aln(b)) begin
			t = K_BAD;
		end else if (is_let(b) || (b == "_")) begin
			t = K_IDENT;
		end else begin
			t = K_BAD;
		end
	end

	always_comb begin
		st_out  = st_in;
		res     = '0;
		res_cnt = 2'd0;
		if (en) begin
			if (st_in.skip_pending) begin
				st_out.skip_pending = 1'b0;
			end else if (!st_in.error_latched) begin
				st_out.prior_byte = b;
				if (st_in.open_kind == K_STRING) begin
					if ((b == "\\") && ((n == "\\") || (n == "\""))) begin
						res[0]              = mk_text(n);
						res_cnt             = 2'd1;
						st_out.skip_pending = 1'b1;
					end else if (b != "\"") begin
						res[0]  = mk_text(b);
						res_cnt = 2'd1;
					end else if (is_aln(n)) begin
						res[0]               = mk_err(ERR_SYNTAX, epos);
						res_cnt              = 2'd1;
						st_out.error_latched = 1'b1;
					end else begin
						res[0]           = mk_done(K_STRING);
						res_cnt          = 2'd1;
						st_out.open_kind = K_NONE;
					end
				end else if (b == "\"") begin
					if (is_aln(st_in.prior_byte)) begin
						res[0]               = mk_err(ERR_SYNTAX, epos);
						res_cnt              = 2'd1;
						st_out.error_latched = 1'b1;
					end else begin
						if (flush_valid(st_in)) begin
							res[0]  = mk_done(flush_code(st_in));
							res_cnt = 2'd1;
						end
						st_out.open_kind = K_STRING;
						st_out.seen_dot  = 1'b0;
					end
				end else if (t == K_BAD) begin
					res[0]               = mk_err(ERR_SYNTAX, epos);
					res_cnt              = 2'd1;
					st_out.error_latched = 1'b1;
				end else if (t == K_SAME) begin
					res[0]          = mk_text(b);
					res_cnt         = 2'd1;
					st_out.seen_dot = st_in.seen_dot | dot_set;
				end else begin
					if (flush_valid(st_in)) begin
						res[0]  = mk_done(flush_code(st_in));
						res_cnt = 2'd1;
					end
					if ((t == K_IDENT) || (t == K_FLOAT)) begin
						if (flush_valid(st_in)) begin
							res[1]  = mk_text(b);
							res_cnt = 2'd2;
						end else begin
							res[0]  = mk_text(b);
							res_cnt = 2'd1;
						end
					end
					st_out.open_kind    = t;
					st_out.seen_dot     = 1'b0;
					st_out.skip_pending = eat;
				end
			end
		end
	end

endmodule
`default_nettype wire

### rtl/exlex_outq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// exlex_outq
// result bank for one input byte, drained one result per transfer
// ----------------------------------------------------------------------------
module exlex_outq (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    load,
	input  wire exlex_pkg::out_t [exlex_pkg::RES_MAX-1:0] load_res,
	input  wire logic [exlex_pkg::CNT_W-1:0]             load_cnt,
	output logic                                         free,
	output logic                                         lex_valid,
	input  wire logic                                    lex_stall,
	output exlex_pkg::out_t                              lex_data
);
	import exlex_pkg::*;

	out_t [RES_MAX-1:0] bank_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   rd_q;
	logic               last_one;

	assign last_one  = (rd_q == (cnt_q - CNT_W'(1)));
	assign lex_valid = (cnt_q != '0);
	assign free      = (cnt_q == '0) || (!lex_stall && last_one);

	always_comb begin
		lex_data          = bank_q[rd_q[RD_W-1:0]];
		lex_data.run_last = last_one;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bank_q <= load_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q  <= '0;
		end else if (load) begin
			cnt_q <= load_cnt;
			rd_q  <= '0;
		end else if (lex_valid && !lex_stall) begin
			if (last_one) begin
				cnt_q <= '0;
				rd_q  <= '0;
			end else begin
				rd_q <= rd_q + CNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire
